@@ rtl/fixed_capacity_sequence_list_assert.svh @@
// Assertion macros for the fixed capacity sequence list.
// Included by the top level; needs nothing but the clock and reset named at each use.
`ifndef FIXED_CAPACITY_SEQUENCE_LIST_ASSERT_SVH
`define FIXED_CAPACITY_SEQUENCE_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCSL_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition must never be seen at a clock edge.
`define FCSL_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

@@ rtl/flist_pkg.sv @@
// Shared constants, operation codes and memory command type of the sequence list.
// No dependencies; imported by the channel interfaces, flist_ctrl and the top level.
`default_nettype none

package flist_pkg;

	localparam int LIST_SIZE = 32;
	localparam int IDX_W     = $clog2(LIST_SIZE);
	localparam int CNT_W     = $clog2(LIST_SIZE + 1);
	localparam int KIND_W    = 3;
	localparam int POS_W     = 6;
	localparam int DATA_W    = 8;
	localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_DELETE = 3'd2,
		KIND_READ   = 3'd3,
		KIND_LOCATE = 3'd4,
		KIND_NEXT   = 3'd5,
		KIND_PREV   = 3'd6
	} kind_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} mem_cmd_t;

endpackage

`default_nettype wire

@@ rtl/flist_chan_if.sv @@
// Valid/ready channel interfaces for list requests and list results.
// Depends on flist_pkg for the field widths.
`default_nettype none

interface flist_req_if
	import flist_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] value;

	modport source (output valid, kind, position, value, input ready);
	modport sink   (input valid, kind, position, value, output ready);
endinterface

interface flist_rsp_if
	import flist_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [DATA_W-1:0] data;
	logic [POS_W-1:0]  match_position;
	logic              found;
	logic              last;
	logic [POS_W-1:0]  count;
	logic              empty_res;

	modport source (output valid, ok, data, match_position, found, last, count, empty_res,
		input ready);
	modport sink   (input valid, ok, data, match_position, found, last, count, empty_res,
		output ready);
endinterface

`default_nettype wire

@@ rtl/flist_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value in cycles without a read. No dependencies.
`default_nettype none

module flist_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/flist_ctrl.sv @@
// Sequencer of the sequence list: decodes requests, walks the element RAM for
// shifts and searches, and holds the result register. Depends on flist_pkg.
`default_nettype none

module flist_ctrl
	import flist_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	flist_req_if.sink              req,
	flist_rsp_if.source            rsp,
	output mem_cmd_t               mem_cmd,
	input  wire logic [DATA_W-1:0] mem_rdata
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SHIFT  = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_FINISH = 5'b01000,
		ST_RESP   = 5'b10000
	} state_t;

	state_t            state_q;
	kind_t             op_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]  ins_addr_q;
	logic [DATA_W-1:0] val_q;
	logic              resp_ok_q;
	logic              rd_sel_q;

	// shift pipeline: a read issued last cycle is written back this cycle
	logic              mv_s1;
	logic [IDX_W-1:0]  wa_s1;

	// search window
	logic              arr_s1;
	logic              cur_v_q;
	logic [DATA_W-1:0] cur_q;
	logic [DATA_W-1:0] prev_q;
	logic [IDX_W-1:0]  cur_idx_q;
	logic              pend_v_q;
	logic [DATA_W-1:0] pend_data_q;
	logic [POS_W-1:0]  pend_mpos_q;

	// result register
	logic              out_v_q;
	logic              o_ok_q;
	logic [DATA_W-1:0] o_data_q;
	logic [POS_W-1:0]  o_mpos_q;
	logic              o_found_q;
	logic              o_last_q;
	logic [POS_W-1:0]  o_count_q;
	logic              o_empty_q;

	logic              accept;
	logic              slot_free;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic              ins_ok;
	logic              at_ok;
	logic [CNT_W-1:0]  moves;
	logic              is_ins;
	logic              shift_move;
	logic              shift_done;
	logic              eval_now;
	logic [DATA_W-1:0] nxt_val;
	logic              hit;
	logic              blocked;
	logic              scan_step;
	logic              scan_done;
	logic [DATA_W-1:0] cand_data;
	logic [POS_W-1:0]  cand_mpos;
	logic              load_scan;
	logic              load_fin;
	logic              load_resp;
	logic              load_any;

	assign accept    = req.valid && req.ready;
	assign slot_free = !out_v_q || rsp.ready;
	assign pos_c     = CMP_W'(req.position);
	assign cnt_c     = CMP_W'(count_q);
	assign ins_ok    = (pos_c <= cnt_c) && (count_q != CNT_W'(LIST_SIZE));
	assign at_ok     = (pos_c != '0) && (pos_c <= cnt_c);
	assign moves     = CNT_W'(cnt_c - pos_c);
	assign is_ins    = (op_q == KIND_INSERT);

	assign shift_move = (state_q == ST_SHIFT) && (rem_q != '0);
	assign shift_done = (state_q == ST_SHIFT) && (rem_q == '0) && !mv_s1;

	// an entry is judged once its right neighbor has arrived or none is left
	assign eval_now  = cur_v_q && (arr_s1 || (rem_q == '0));
	assign nxt_val   = arr_s1 ? mem_rdata : '0;
	assign hit       = eval_now && (cur_q == val_q);
	assign blocked   = hit && pend_v_q && !slot_free;
	assign scan_step = (state_q == ST_SCAN) && !blocked;
	assign scan_done = (rem_q == '0) && !arr_s1 && !cur_v_q;
	assign cand_mpos = POS_W'(cur_idx_q) + POS_W'(1);

	always_comb begin
		case (op_q)
			KIND_NEXT: cand_data = nxt_val;
			KIND_PREV: cand_data = prev_q;
			default:   cand_data = '0;
		endcase
	end

	assign load_scan = scan_step && hit && pend_v_q;
	assign load_fin  = (state_q == ST_FINISH) && slot_free;
	assign load_resp = (state_q == ST_RESP) && slot_free;
	assign load_any  = load_scan || load_fin || load_resp;

	always_comb begin
		mem_cmd = '0;
		if (accept) begin
			mem_cmd.re    = (kind_t'(req.kind) == KIND_READ) && at_ok;
			mem_cmd.raddr = IDX_W'(req.position - POS_W'(1));
		end else begin
			mem_cmd.re    = shift_move || (scan_step && !scan_done && (rem_q != '0));
			mem_cmd.raddr = rd_ptr_q;
		end
		mem_cmd.we    = ((state_q == ST_SHIFT) && mv_s1) || (shift_done && is_ins);
		mem_cmd.waddr = mv_s1 ? wa_s1 : ins_addr_q;
		mem_cmd.wdata = mv_s1 ? mem_rdata : val_q;
	end

	assign req.ready = (state_q == ST_IDLE);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= KIND_CLEAR;
			count_q  <= '0;
			rem_q    <= '0;
			mv_s1    <= 1'b0;
			arr_s1   <= 1'b0;
			cur_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (load_any) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= kind_t'(req.kind);
						case (kind_t'(req.kind))
							KIND_CLEAR: begin
								count_q <= '0;
								state_q <= ST_RESP;
							end
							KIND_INSERT: begin
								rem_q   <= moves;
								state_q <= ins_ok ? ST_SHIFT : ST_RESP;
							end
							KIND_DELETE: begin
								rem_q   <= moves;
								state_q <= at_ok ? ST_SHIFT : ST_RESP;
							end
							KIND_LOCATE, KIND_NEXT, KIND_PREV: begin
								rem_q    <= count_q;
								arr_s1   <= 1'b0;
								cur_v_q  <= 1'b0;
								pend_v_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					mv_s1 <= shift_move;
					if (shift_move) begin
						rem_q <= rem_q - CNT_W'(1);
					end
					if (shift_done) begin
						count_q <= is_ins ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
						state_q <= ST_RESP;
					end
				end
				ST_SCAN: begin
					if (scan_step) begin
						if (scan_done) begin
							state_q <= ST_FINISH;
						end else begin
							if (arr_s1) begin
								cur_v_q <= 1'b1;
							end else if (eval_now) begin
								cur_v_q <= 1'b0;
							end
							if (hit) begin
								pend_v_q <= 1'b1;
							end
							if (rem_q != '0) begin
								rem_q  <= rem_q - CNT_W'(1);
								arr_s1 <= 1'b1;
							end else begin
								arr_s1 <= 1'b0;
							end
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q      <= req.value;
			ins_addr_q <= IDX_W'(req.position);
			rd_sel_q   <= 1'b0;
			resp_ok_q  <= 1'b0;
			prev_q     <= '0;
			case (kind_t'(req.kind))
				KIND_CLEAR: begin
					resp_ok_q <= 1'b1;
				end
				KIND_INSERT: begin
					resp_ok_q <= ins_ok;
					rd_ptr_q  <= IDX_W'(count_q - CNT_W'(1));
				end
				KIND_DELETE: begin
					resp_ok_q <= at_ok;
					rd_ptr_q  <= IDX_W'(req.position);
				end
				KIND_READ: begin
					resp_ok_q <= at_ok;
					rd_sel_q  <= at_ok;
				end
				KIND_LOCATE, KIND_NEXT, KIND_PREV: begin
					rd_ptr_q <= '0;
				end
				default: begin
					resp_ok_q <= 1'b0;
				end
			endcase
		end

		if (shift_move) begin
			rd_ptr_q <= is_ins ? rd_ptr_q - IDX_W'(1) : rd_ptr_q + IDX_W'(1);
			wa_s1    <= is_ins ? rd_ptr_q + IDX_W'(1) : rd_ptr_q - IDX_W'(1);
		end

		if (scan_step && !scan_done) begin
			if (arr_s1) begin
				prev_q    <= cur_v_q ? cur_q : '0;
				cur_q     <= mem_rdata;
				cur_idx_q <= cur_v_q ? cur_idx_q + IDX_W'(1) : '0;
			end
			if (hit) begin
				pend_data_q <= cand_data;
				pend_mpos_q <= cand_mpos;
			end
			if (rem_q != '0) begin
				rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
		end

		if (load_any) begin
			o_count_q <= POS_W'(count_q);
			o_empty_q <= (count_q == '0);
		end
		if (load_scan || (load_fin && pend_v_q)) begin
			o_ok_q    <= 1'b1;
			o_data_q  <= pend_data_q;
			o_mpos_q  <= pend_mpos_q;
			o_found_q <= 1'b1;
			o_last_q  <= load_fin;
		end else if (load_fin) begin
			// nothing matched: single not-found beat
			o_ok_q    <= 1'b1;
			o_data_q  <= '0;
			o_mpos_q  <= '0;
			o_found_q <= 1'b0;
			o_last_q  <= 1'b1;
		end else if (load_resp) begin
			o_ok_q    <= resp_ok_q;
			o_data_q  <= rd_sel_q ? mem_rdata : '0;
			o_mpos_q  <= '0;
			o_found_q <= 1'b0;
			o_last_q  <= 1'b1;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.ok             = o_ok_q;
	assign rsp.data           = o_data_q;
	assign rsp.match_position = o_mpos_q;
	assign rsp.found          = o_found_q;
	assign rsp.last           = o_last_q;
	assign rsp.count          = o_count_q;
	assign rsp.empty_res      = o_empty_q;

endmodule

`default_nettype wire

@@ rtl/fixed_capacity_sequence_list.sv @@
// Fixed capacity sequence list: up to LIST_SIZE byte elements kept in order in a
// single-port-read, single-port-write RAM with registered read data. One request
// is worked on at a time; the next request is taken as soon as the previous one has
// placed its last result beat in the output register. Insert and delete move
// (count - position) entries; locate, next and previous read all count entries.
// Every element moved or compared passes once through the RAM read port, one entry
// per cycle, though a search pauses while a result beat waits in the output register.
// Search requests return one beat per match in ascending position, the final one
// marked by last, or a single not-found beat. Depends on flist_pkg, the channel
// interfaces, flist_ram, flist_ctrl and the assertion macro header.
`default_nettype none

`include "fixed_capacity_sequence_list_assert.svh"

module fixed_capacity_sequence_list
	import flist_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	flist_req_if.sink   req,
	flist_rsp_if.source rsp
);

	mem_cmd_t          mem_cmd;
	logic [DATA_W-1:0] mem_rdata;

	flist_ram #(
		.DEPTH (LIST_SIZE),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_cmd.we),
		.waddr (mem_cmd.waddr),
		.wdata (mem_cmd.wdata),
		.re    (mem_cmd.re),
		.raddr (mem_cmd.raddr),
		.rdata (mem_rdata)
	);

	flist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_cmd   (mem_cmd),
		.mem_rdata (mem_rdata)
	);

	`FCSL_ASSERT_NEVER(a_no_write_when_idle, clk, arst_n, mem_cmd.we && req.ready, "element store written while idle")
	`FCSL_ASSERT_IMPL(a_found_has_pos, clk, arst_n, rsp.valid && rsp.found, rsp.ok && (rsp.match_position != '0), "match beat without position")
	`FCSL_ASSERT_IMPL(a_reject_single, clk, arst_n, rsp.valid && !rsp.ok, rsp.last && !rsp.found && (rsp.data == '0), "rejected request gave more than a bare beat")

endmodule

`default_nettype wire
